FILE: hdl/aet_pkg.sv
// Shared types, constants and helpers for the adjacency edge table.
package aet_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int MAX_DEGREE   = 16;

	localparam int OP_W   = 3;
	localparam int VERT_W = 8;
	localparam int ST_W   = 3;
	localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int NB_DEPTH = MAX_VERTICES * MAX_DEGREE;
	localparam int NB_AW  = $clog2(NB_DEPTH);

	typedef logic [VERT_W-1:0] vert_t;
	typedef logic [VIDX_W-1:0] vidx_t;
	typedef logic [DEG_W-1:0]  deg_t;
	typedef logic [NB_AW-1:0]  nb_addr_t;
	typedef logic [OP_W-1:0]   op_t;

	typedef enum logic [OP_W-1:0] {
		OP_ADD_UND = 3'd0,
		OP_ADD_DIR = 3'd1,
		OP_REMOVE  = 3'd2,
		OP_CHECK   = 3'd3,
		OP_CLEAR   = 3'd4
	} op_code_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE    = 3'd0,
		ST_FOUND   = 3'd1,
		ST_ABSENT  = 3'd2,
		ST_BADVERT = 3'd3,
		ST_FULL    = 3'd4,
		ST_INCONS  = 3'd5
	} rsp_code_t;

	// Controller to datapath
	typedef struct packed {
		logic      load_in;
		logic      deg_rd;
		logic      sel_b;
		logic      cap_deg_a;
		logic      cap_deg_b;
		logic      clear;
		logic      add;
		logic      scan_start;
		logic      start_after_pa;
		logic      store_pb;
		logic      drop_start;
		logic      pos_pb;
		logic      load_out;
		rsp_code_t res_code;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic verts_ok;
		logic a_eq_b;
		logic room_und;
		logic room_dir;
		logic scan_done;
		logic scan_hit;
		logic shift_done;
		logic out_free;
	} dp_sts_t;

	// Flat address of entry pos in the list of vertex v
	function automatic nb_addr_t nb_addr(vidx_t v, deg_t pos);
		return nb_addr_t'(v) * nb_addr_t'(MAX_DEGREE) + nb_addr_t'(pos);
	endfunction

endpackage

FILE: hdl/aet_if.sv
// Request and response channel interfaces of the adjacency edge table.
interface aet_req_if;
	logic                       valid;
	logic                       ready;
	logic [aet_pkg::OP_W-1:0]   op;
	logic [aet_pkg::VERT_W-1:0] first_vertex;
	logic [aet_pkg::VERT_W-1:0] second_vertex;

	modport source (output valid, op, first_vertex, second_vertex, input ready);
	modport sink (input valid, op, first_vertex, second_vertex, output ready);
endinterface

interface aet_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [aet_pkg::ST_W-1:0]  status;
	logic [aet_pkg::DEG_W-1:0] degree_after;

	modport source (output valid, status, degree_after, input ready);
	modport sink (input valid, status, degree_after, output ready);
endinterface

FILE: hdl/aet_datapath.sv
// Datapath: degree and neighbour memories, list scan/shift engine, result register.
module aet_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  aet_pkg::dp_cmd_t           cmd,
	output aet_pkg::dp_sts_t           sts,
	input  logic [aet_pkg::OP_W-1:0]   req_op,
	input  logic [aet_pkg::VERT_W-1:0] req_first_vertex,
	input  logic [aet_pkg::VERT_W-1:0] req_second_vertex,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic [aet_pkg::ST_W-1:0]   rsp_status,
	output logic [aet_pkg::DEG_W-1:0]  rsp_degree_after
);

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_SCAN  = 3'b010,
		MODE_SHIFT = 3'b100
	} mode_t;

	aet_pkg::deg_t  deg_mem [aet_pkg::MAX_VERTICES];
	aet_pkg::vert_t nb_mem  [aet_pkg::NB_DEPTH];
	logic [aet_pkg::MAX_VERTICES-1:0] deg_vld_q;

	aet_pkg::op_t   op_q;
	aet_pkg::vert_t a_q, b_q;
	logic           a_ok_q, b_ok_q;
	aet_pkg::deg_t  deg_a_q, deg_b_q, pa_q, pb_q, idx_q, deg_rd_q;
	aet_pkg::vert_t nb_rd_q;
	logic           sel_q, store_pb_q;
	mode_t          mode_q;
	logic           rd_vld_s1;
	aet_pkg::deg_t  rd_idx_s1;
	logic           out_vld_q;
	aet_pkg::rsp_code_t out_status_q;
	aet_pkg::deg_t  out_degree_q;

	aet_pkg::vidx_t    a_idx, b_idx, cur_v, add_v, deg_raddr, deg_waddr;
	aet_pkg::deg_t     cur_deg, add_deg, deg_wdata;
	aet_pkg::vert_t    target, add_other, nb_wdata;
	aet_pkg::nb_addr_t nb_raddr, nb_waddr;
	logic              hit, issue, scan_done, shift_done, nb_we, deg_we;

	always_comb begin
		a_idx     = aet_pkg::vidx_t'(a_q);
		b_idx     = aet_pkg::vidx_t'(b_q);
		// engine works on the latched vertex; the other vertex is the search key
		cur_v     = sel_q ? b_idx : a_idx;
		cur_deg   = sel_q ? deg_b_q : deg_a_q;
		target    = sel_q ? a_q : b_q;
		add_v     = cmd.sel_b ? b_idx : a_idx;
		add_deg   = cmd.sel_b ? deg_b_q : deg_a_q;
		add_other = cmd.sel_b ? a_q : b_q;

		hit        = (mode_q == MODE_SCAN) && rd_vld_s1 && (nb_rd_q == target);
		issue      = (mode_q != MODE_IDLE) && (idx_q < cur_deg) && !hit;
		scan_done  = (mode_q == MODE_SCAN) && (hit || (!rd_vld_s1 && (idx_q >= cur_deg)));
		shift_done = (mode_q == MODE_SHIFT) && !rd_vld_s1 && (idx_q >= cur_deg);

		nb_raddr = aet_pkg::nb_addr(cur_v, idx_q);
		if (cmd.add) begin
			nb_we    = 1'b1;
			nb_waddr = aet_pkg::nb_addr(add_v, add_deg);
			nb_wdata = add_other;
		end else begin
			// shift: entry read last cycle moves one place down
			nb_we    = (mode_q == MODE_SHIFT) && rd_vld_s1;
			nb_waddr = aet_pkg::nb_addr(cur_v, rd_idx_s1 - aet_pkg::deg_t'(1));
			nb_wdata = nb_rd_q;
		end

		deg_we    = cmd.add || shift_done;
		deg_waddr = cmd.add ? add_v : cur_v;
		deg_wdata = cmd.add ? add_deg + aet_pkg::deg_t'(1) : cur_deg - aet_pkg::deg_t'(1);
		deg_raddr = cmd.sel_b ? b_idx : a_idx;
	end

	always_ff @(posedge clk) begin
		if (nb_we) begin
			nb_mem[nb_waddr] <= nb_wdata;
		end
		nb_rd_q <= nb_mem[nb_raddr];
	end

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_waddr] <= deg_wdata;
		end
		if (cmd.deg_rd) begin
			deg_rd_q <= deg_vld_q[deg_raddr] ? deg_mem[deg_raddr] : '0;
		end
	end

	// an entry never written since reset or clear reads as degree zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_vld_q <= '0;
		end else if (cmd.clear) begin
			deg_vld_q <= '0;
		end else if (deg_we) begin
			deg_vld_q[deg_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.scan_start) begin
				mode_q <= MODE_SCAN;
			end else if (cmd.drop_start) begin
				mode_q <= MODE_SHIFT;
			end else if (scan_done || shift_done) begin
				mode_q <= MODE_IDLE;
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= req_op;
			a_q    <= req_first_vertex;
			b_q    <= req_second_vertex;
			a_ok_q <= int'(req_first_vertex) < aet_pkg::MAX_VERTICES;
			b_ok_q <= int'(req_second_vertex) < aet_pkg::MAX_VERTICES;
		end

		rd_idx_s1 <= idx_q;
		if (cmd.scan_start) begin
			idx_q      <= cmd.start_after_pa ? pa_q + aet_pkg::deg_t'(1) : '0;
			sel_q      <= cmd.sel_b;
			store_pb_q <= cmd.store_pb;
		end else if (cmd.drop_start) begin
			idx_q <= (cmd.pos_pb ? pb_q : pa_q) + aet_pkg::deg_t'(1);
			sel_q <= cmd.sel_b;
		end else if (issue) begin
			idx_q <= idx_q + aet_pkg::deg_t'(1);
		end

		if (hit) begin
			if (store_pb_q) begin
				pb_q <= rd_idx_s1;
			end else begin
				pa_q <= rd_idx_s1;
			end
		end

		if (cmd.clear) begin
			deg_a_q <= '0;
			deg_b_q <= '0;
		end else if (cmd.cap_deg_a) begin
			deg_a_q <= deg_rd_q;
		end else if (cmd.cap_deg_b) begin
			deg_b_q <= deg_rd_q;
		end else if (cmd.add) begin
			if (cmd.sel_b) begin
				deg_b_q <= deg_wdata;
			end else begin
				deg_a_q <= deg_wdata;
			end
		end else if (shift_done) begin
			if (sel_q) begin
				deg_b_q <= deg_wdata;
			end else begin
				deg_a_q <= deg_wdata;
			end
		end

		if (cmd.load_out) begin
			out_status_q <= cmd.res_code;
			out_degree_q <= a_ok_q ? deg_a_q : '0;
		end
	end

	always_comb begin
		sts.op         = op_q;
		sts.verts_ok   = a_ok_q && b_ok_q;
		sts.a_eq_b     = (a_q == b_q);
		sts.room_und   = (a_q == b_q) ? ((int'(deg_a_q) + 2) <= aet_pkg::MAX_DEGREE)
			: ((int'(deg_a_q) < aet_pkg::MAX_DEGREE) && (int'(deg_b_q) < aet_pkg::MAX_DEGREE));
		sts.room_dir   = int'(deg_a_q) < aet_pkg::MAX_DEGREE;
		sts.scan_done  = scan_done;
		sts.scan_hit   = hit;
		sts.shift_done = shift_done;
		sts.out_free   = !out_vld_q || rsp_ready;
	end

	assign rsp_valid        = out_vld_q;
	assign rsp_status       = out_status_q;
	assign rsp_degree_after = out_degree_q;

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_SCAN) |-> !nb_we)
		else $error("neighbour write during list scan");

	a_deg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		deg_we |-> (int'(deg_wdata) <= aet_pkg::MAX_DEGREE))
		else $error("degree written above list capacity");

	a_no_cmd_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_IDLE) |-> !(cmd.scan_start || cmd.drop_start || cmd.add))
		else $error("list command issued while engine busy");

	a_load_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_vld_q || rsp_ready))
		else $error("result overwritten before it was taken");

endmodule

FILE: hdl/aet_ctrl.sv
// Controller: sequences degree reads, adds, list scans and shifts per request item.
module aet_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  aet_pkg::dp_sts_t sts,
	output aet_pkg::dp_cmd_t cmd
);

	typedef enum logic [14:0] {
		S_IDLE     = 15'h0001,
		S_RD_A     = 15'h0002,
		S_RD_B     = 15'h0004,
		S_EVAL     = 15'h0008,
		S_DISPATCH = 15'h0010,
		S_ADD1     = 15'h0020,
		S_ADD2     = 15'h0040,
		S_FIND_A   = 15'h0080,
		S_START2   = 15'h0100,
		S_FIND2    = 15'h0200,
		S_DROP1    = 15'h0400,
		S_SHIFT1   = 15'h0800,
		S_DROP2    = 15'h1000,
		S_SHIFT2   = 15'h2000,
		S_RESP     = 15'h4000
	} state_t;

	state_t             state_q, state_d;
	aet_pkg::rsp_code_t code_q, code_d;

	always_comb begin
		state_d   = state_q;
		code_d    = code_q;
		cmd       = '0;
		cmd.res_code = code_q;
		req_ready = 1'b0;

		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_RD_A;
				end
			end
			S_RD_A: begin
				cmd.deg_rd = 1'b1;
				state_d    = S_RD_B;
			end
			S_RD_B: begin
				cmd.deg_rd    = 1'b1;
				cmd.sel_b     = 1'b1;
				cmd.cap_deg_a = 1'b1;
				state_d       = S_EVAL;
			end
			S_EVAL: begin
				cmd.cap_deg_b = 1'b1;
				state_d       = S_DISPATCH;
			end
			S_DISPATCH: begin
				code_d  = aet_pkg::ST_DONE;
				state_d = S_RESP;
				case (sts.op)
					aet_pkg::OP_CLEAR: begin
						cmd.clear = 1'b1;
					end
					aet_pkg::OP_ADD_UND, aet_pkg::OP_ADD_DIR: begin
						if (!sts.verts_ok) begin
							code_d = aet_pkg::ST_BADVERT;
						end else if ((sts.op == aet_pkg::OP_ADD_UND) ? sts.room_und
								: sts.room_dir) begin
							state_d = S_ADD1;
						end else begin
							code_d = aet_pkg::ST_FULL;
						end
					end
					aet_pkg::OP_REMOVE, aet_pkg::OP_CHECK: begin
						if (!sts.verts_ok) begin
							code_d = aet_pkg::ST_BADVERT;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_FIND_A;
						end
					end
					default: begin
						code_d = aet_pkg::ST_DONE;
					end
				endcase
			end
			S_ADD1: begin
				cmd.add = 1'b1;
				code_d  = aet_pkg::ST_DONE;
				state_d = (sts.op == aet_pkg::OP_ADD_UND) ? S_ADD2 : S_RESP;
			end
			S_ADD2: begin
				// self-loop puts both entries in the first vertex's list
				cmd.add   = 1'b1;
				cmd.sel_b = !sts.a_eq_b;
				state_d   = S_RESP;
			end
			S_FIND_A: begin
				if (sts.scan_done) begin
					if (!sts.scan_hit) begin
						code_d  = aet_pkg::ST_ABSENT;
						state_d = S_RESP;
					end else if (sts.op == aet_pkg::OP_CHECK) begin
						code_d  = aet_pkg::ST_FOUND;
						state_d = S_RESP;
					end else begin
						state_d = S_START2;
					end
				end
			end
			S_START2: begin
				// reverse entry, or the second copy for a self-loop
				cmd.scan_start     = 1'b1;
				cmd.sel_b          = !sts.a_eq_b;
				cmd.start_after_pa = sts.a_eq_b;
				cmd.store_pb       = 1'b1;
				state_d            = S_FIND2;
			end
			S_FIND2: begin
				if (sts.scan_done) begin
					if (!sts.scan_hit) begin
						code_d  = aet_pkg::ST_INCONS;
						state_d = S_RESP;
					end else begin
						state_d = S_DROP1;
					end
				end
			end
			S_DROP1: begin
				// later position goes first so the earlier one stays put
				cmd.drop_start = 1'b1;
				cmd.sel_b      = !sts.a_eq_b;
				cmd.pos_pb     = 1'b1;
				state_d        = S_SHIFT1;
			end
			S_SHIFT1: begin
				if (sts.shift_done) begin
					state_d = S_DROP2;
				end
			end
			S_DROP2: begin
				cmd.drop_start = 1'b1;
				state_d        = S_SHIFT2;
			end
			S_SHIFT2: begin
				if (sts.shift_done) begin
					code_d  = aet_pkg::ST_DONE;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= aet_pkg::ST_DONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

FILE: hdl/adjacency_edge_table_top.sv
// Adjacency edge table top: one request item in, one status item out.
// Holds a degree per vertex and a neighbour list of up to MAX_DEGREE entries per vertex in a
// single-port-read neighbour memory, so list work goes one entry per cycle. An add writes one
// entry, two for an undirected edge; a check scans one list, and a removal runs up to two scans
// and two shifts through that memory port (a scan stops at its match and the shift covers the
// rest of the list). A new request is taken as soon as the previous result sits in the output
// register, even if it has not yet been taken. Degrees come up zero at reset, and clear sets
// them all to zero; neither needs a clearing pass.
module adjacency_edge_table_top (
	input logic        clk,
	input logic        arst_n,
	aet_req_if.sink    req,
	aet_rsp_if.source  rsp
);

	aet_pkg::dp_cmd_t cmd;
	aet_pkg::dp_sts_t sts;

	aet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	aet_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.req_op            (req.op),
		.req_first_vertex  (req.first_vertex),
		.req_second_vertex (req.second_vertex),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.rsp_status        (rsp.status),
		.rsp_degree_after  (rsp.degree_after)
	);

endmodule

FILE: test/tb_adjacency_edge_table_top.sv
// Testbench for the adjacency edge table: queued directed and random requests, shadow graph, response check.
`timescale 1ns / 1ps

module tb_adjacency_edge_table_top;
	import aet_pkg::*;

	typedef struct {
		op_t   op;
		vert_t a;
		vert_t b;
	} edge_req_t;

	typedef struct {
		logic [ST_W-1:0] status;
		deg_t            degree;
	} edge_rsp_t;

	logic clk;
	logic arst_n;

	aet_req_if req_ch ();
	aet_rsp_if rsp_ch ();

	adjacency_edge_table_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow graph
	deg_t  vertex_deg [MAX_VERTICES];
	vert_t adj_list   [MAX_VERTICES][MAX_DEGREE];

	edge_req_t pending_reqs [$];
	edge_rsp_t expected_rsps [$];
	edge_req_t next_req;
	edge_rsp_t got_rsp;

	logic req_fire;
	logic rsp_fire;
	int   src_wait;
	int   snk_wait;
	bit   src_burst;
	bit   snk_burst;
	int   err_count;

	function automatic int find_pos(vert_t v, vert_t target, int start);
		int i;
		for (i = start; i < int'(vertex_deg[v]); i++) begin
			if (adj_list[v][i] == target)
				return i;
		end
		return int'(vertex_deg[v]);
	endfunction

	function automatic void drop_pos(vert_t v, int pos);
		int i;
		for (i = pos + 1; i < int'(vertex_deg[v]); i++)
			adj_list[v][i-1] = adj_list[v][i];
		vertex_deg[v] = vertex_deg[v] - 1'b1;
	endfunction

	function automatic void push_neighbour(vert_t v, vert_t w);
		adj_list[v][vertex_deg[v]] = w;
		vertex_deg[v] = vertex_deg[v] + 1'b1;
	endfunction

	// Applies one request to the shadow graph and returns the response it should produce
	function automatic edge_rsp_t apply_request(edge_req_t r);
		edge_rsp_t res;
		bit        verts_ok;
		bit        room;
		int        pa;
		int        pb;
		int        p2;
		verts_ok = int'(r.a) < MAX_VERTICES && int'(r.b) < MAX_VERTICES;
		res.status = ST_DONE;
		if (r.op == OP_CLEAR) begin
			for (int v = 0; v < MAX_VERTICES; v++)
				vertex_deg[v] = '0;
		end else if (r.op <= OP_CHECK && !verts_ok) begin
			res.status = ST_BADVERT;
		end else begin
			case (r.op)
				OP_ADD_UND: begin
					if (r.a == r.b)
						room = int'(vertex_deg[r.a]) + 2 <= MAX_DEGREE;
					else
						room = int'(vertex_deg[r.a]) < MAX_DEGREE &&
							int'(vertex_deg[r.b]) < MAX_DEGREE;
					if (room) begin
						push_neighbour(r.a, r.b);
						push_neighbour(r.b, r.a);
					end else begin
						res.status = ST_FULL;
					end
				end
				OP_ADD_DIR: begin
					if (int'(vertex_deg[r.a]) < MAX_DEGREE)
						push_neighbour(r.a, r.b);
					else
						res.status = ST_FULL;
				end
				OP_REMOVE: begin
					pa = find_pos(r.a, r.b, 0);
					if (pa == int'(vertex_deg[r.a])) begin
						res.status = ST_ABSENT;
					end else if (r.a == r.b) begin
						// self-loop: needs a second copy further along the same list
						p2 = find_pos(r.a, r.a, pa + 1);
						if (p2 == int'(vertex_deg[r.a])) begin
							res.status = ST_INCONS;
						end else begin
							drop_pos(r.a, p2);
							drop_pos(r.a, pa);
						end
					end else begin
						pb = find_pos(r.b, r.a, 0);
						if (pb == int'(vertex_deg[r.b])) begin
							res.status = ST_INCONS;
						end else begin
							drop_pos(r.a, pa);
							drop_pos(r.b, pb);
						end
					end
				end
				OP_CHECK: begin
					res.status = (find_pos(r.a, r.b, 0) < int'(vertex_deg[r.a])) ?
						ST_FOUND : ST_ABSENT;
				end
				default: ;
			endcase
		end
		res.degree = (int'(r.a) < MAX_VERTICES) ? vertex_deg[r.a] : '0;
		return res;
	endfunction

	function automatic int draw_wait(inout bit burst);
		if ($urandom_range(0, 49) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, 10);
	endfunction

	task automatic queue_req(op_t op, int a, int b);
		edge_req_t r;
		r.op = op;
		r.a  = vert_t'(a);
		r.b  = vert_t'(b);
		pending_reqs.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	// Request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_ch.valid || req_fire) begin
				if (src_wait > 0) begin
					src_wait--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					next_req = pending_reqs.pop_front();
					req_ch.op            <= next_req.op;
					req_ch.first_vertex  <= next_req.a;
					req_ch.second_vertex <= next_req.b;
					req_ch.valid         <= 1'b1;
					src_wait = draw_wait(src_burst);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_fire)
				snk_wait = draw_wait(snk_burst);
			if (snk_wait > 0) begin
				snk_wait--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: check accepted responses, then predict the accepted request
	always @(posedge clk) begin
		rsp_fire <= rsp_ch.valid && rsp_ch.ready;
		req_fire <= req_ch.valid && req_ch.ready;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected response item: status %0d degree_after %0d",
					rsp_ch.status, rsp_ch.degree_after);
				err_count++;
			end else begin
				got_rsp = expected_rsps.pop_front();
				if (rsp_ch.status !== got_rsp.status) begin
					$error("status: expected %0d, actual %0d", got_rsp.status, rsp_ch.status);
					err_count++;
				end
				if (rsp_ch.degree_after !== got_rsp.degree) begin
					$error("degree_after: expected %0d, actual %0d",
						got_rsp.degree, rsp_ch.degree_after);
					err_count++;
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			next_req.op = req_ch.op;
			next_req.a  = req_ch.first_vertex;
			next_req.b  = req_ch.second_vertex;
			expected_rsps.push_back(apply_request(next_req));
		end
	end

	initial begin
		int   base;
		int   width;
		int   pick;
		int   a;
		int   b;
		op_t  op;
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.op            = OP_CLEAR;
		req_ch.first_vertex  = '0;
		req_ch.second_vertex = '0;
		rsp_ch.ready         = 1'b0;
		req_fire             = 1'b0;
		rsp_fire             = 1'b0;
		src_wait             = 0;
		snk_wait             = 0;
		src_burst            = 1'b0;
		snk_burst            = 1'b0;
		err_count            = 0;
		for (int v = 0; v < MAX_VERTICES; v++)
			vertex_deg[v] = '0;

		// Directed part
		queue_req(OP_CHECK, 0, 255);
		queue_req(OP_ADD_UND, 0, 255);
		queue_req(OP_CHECK, 255, 0);
		queue_req(OP_ADD_DIR, 1, 2);
		queue_req(OP_REMOVE, 1, 2);      // reverse entry missing
		queue_req(OP_REMOVE, 2, 1);      // nothing in the list
		queue_req(OP_ADD_UND, 3, 3);
		queue_req(OP_REMOVE, 3, 3);
		queue_req(OP_ADD_DIR, 3, 3);
		queue_req(OP_REMOVE, 3, 3);      // only one copy of the self-loop
		queue_req(OP_ADD_UND, 5, 6);
		queue_req(OP_ADD_UND, 5, 6);     // duplicate
		queue_req(OP_REMOVE, 5, 6);
		queue_req(OP_CHECK, 6, 5);
		for (int i = 0; i < MAX_DEGREE / 2; i++)
			queue_req(OP_ADD_UND, 7, 7);
		queue_req(OP_ADD_UND, 7, 7);     // list full
		queue_req(OP_ADD_DIR, 7, 0);
		queue_req(OP_ADD_UND, 8, 7);
		for (int u = int'(OP_CLEAR) + 1; u < (1 << OP_W); u++)
			queue_req(op_t'(u), 255, 255);
		queue_req(OP_CLEAR, 0, 0);
		queue_req(OP_CHECK, 0, 255);

		// Random part: small vertex windows so lists fill, collide and empty again
		base  = 0;
		width = 1;
		for (int n = 0; n < 1500; n++) begin
			if (n % 60 == 0) begin
				base  = $urandom_range(0, 255);
				width = $urandom_range(1, 6);
			end
			a = (base + $urandom_range(0, width - 1)) % MAX_VERTICES;
			b = (base + $urandom_range(0, width - 1)) % MAX_VERTICES;
			if ($urandom_range(0, 9) == 0)
				a = $urandom_range(0, 255);
			if ($urandom_range(0, 9) == 0)
				b = $urandom_range(0, 255);
			pick = $urandom_range(0, 99);
			if (pick < 35)
				op = OP_ADD_UND;
			else if (pick < 47)
				op = OP_ADD_DIR;
			else if (pick < 77)
				op = OP_REMOVE;
			else if (pick < 94)
				op = OP_CHECK;
			else if (pick < 95)
				op = OP_CLEAR;
			else
				op = op_t'($urandom_range(int'(OP_CLEAR) + 1, (1 << OP_W) - 1));
			queue_req(op, a, b);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/aet_pkg.sv
hdl/aet_if.sv
hdl/aet_datapath.sv
hdl/aet_ctrl.sv
hdl/adjacency_edge_table_top.sv
test/tb_adjacency_edge_table_top.sv
